### design/slhl_pkg.sv
package slhl_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 20;
    localparam int WINDOW_BITS = 20;
    localparam int TOL_BITS    = 10;
    localparam int INDEX_BITS  = 2;

    // Width used to compare the elapsed count against the window length.
    localparam int CMP_BITS = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;
    // Width that holds lowest + 2*tolerance without overflow.
    localparam int BOUND_BITS = ((SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS) + 2;

    localparam logic [INDEX_BITS-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_BYPASS     = 2'd2;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 20'd5000;
    localparam logic [TOL_BITS-1:0]    TOL_RESET    = 10'd10;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] window_len;
        logic [TOL_BITS-1:0]    tolerance;
        logic                   bypass;
    } cfg_t;

    typedef struct packed {
        logic                   locked;
        logic [SAMPLE_BITS-1:0] held;
        logic [SAMPLE_BITS-1:0] lowest;
        logic [COUNT_BITS-1:0]  elapsed;
    } state_t;

endpackage

### design/slhl_step.sv
module slhl_step (
    input  slhl_pkg::cfg_t                     cfg,
    input  slhl_pkg::state_t                   state,
    input  logic [slhl_pkg::SAMPLE_BITS-1:0]   sample,
    output slhl_pkg::state_t                   state_next,
    output logic [slhl_pkg::SAMPLE_BITS-1:0]   out_value,
    output logic                               is_locked
);

    logic [slhl_pkg::COUNT_BITS-1:0] count_inc;
    logic                            in_band;
    logic                            unlock;
    logic                            window_done;
    logic [slhl_pkg::BOUND_BITS-1:0] s_ext;
    logic [slhl_pkg::BOUND_BITS-1:0] held_ext;
    logic [slhl_pkg::BOUND_BITS-1:0] low_ext;
    logic [slhl_pkg::BOUND_BITS-1:0] tol_ext;

    assign s_ext    = slhl_pkg::BOUND_BITS'(sample);
    assign held_ext = slhl_pkg::BOUND_BITS'(state.held);
    assign low_ext  = slhl_pkg::BOUND_BITS'(state.lowest);
    assign tol_ext  = slhl_pkg::BOUND_BITS'(cfg.tolerance);

    assign count_inc = (&state.elapsed) ? state.elapsed
                                        : state.elapsed + slhl_pkg::COUNT_BITS'(1);

    // held - tol < s < held + tol, rearranged so nothing goes negative.
    assign in_band = (held_ext < s_ext + tol_ext) && (s_ext < held_ext + tol_ext);

    // s > lowest + 2*tol - 2, rearranged as s + 2 > lowest + 2*tol.
    assign unlock = (s_ext + slhl_pkg::BOUND_BITS'(2)) > (low_ext + (tol_ext << 1));

    assign window_done = slhl_pkg::CMP_BITS'(count_inc) > slhl_pkg::CMP_BITS'(cfg.window_len);

    always_comb
    begin
        state_next         = state;
        state_next.elapsed = count_inc;
        out_value          = sample;
        if (cfg.bypass)
        begin
            state_next = state;
        end
        else if (state.locked)
        begin
            if (unlock)
            begin
                state_next.locked  = 1'b0;
                state_next.held    = sample;
                state_next.elapsed = '0;
            end
            else
            begin
                if (sample < state.lowest)
                begin
                    state_next.lowest = sample;
                end
                out_value = state.held;
            end
        end
        else if (in_band)
        begin
            if (window_done)
            begin
                state_next.locked = 1'b1;
                state_next.held   = sample;
                state_next.lowest = sample;
            end
        end
        else
        begin
            state_next.held    = sample;
            state_next.elapsed = '0;
        end
        is_locked = cfg.bypass ? 1'b0 : state_next.locked;
    end

endmodule

### design/stable_level_hold_lock_core.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   sample
// out       output     out_valid / out_stall out_value, is_locked
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample per cycle unless stalled; a result shows the cycle after its sample.
// Lock, held, lowest and elapsed state update on accepted samples outside bypass.
// Reset clears the lock state and loads the register defaults.
// A stalled result holds in the output register; in_stall rises only while it waits.
module stable_level_hold_lock_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [slhl_pkg::SAMPLE_BITS-1:0]    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [slhl_pkg::SAMPLE_BITS-1:0]    out_value,
    output logic                                is_locked,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slhl_pkg::INDEX_BITS-1:0]     cfg_index,
    input  logic [slhl_pkg::WINDOW_BITS-1:0]    cfg_data
);

    slhl_pkg::cfg_t                   cfg_reg;
    slhl_pkg::state_t                 state_reg;
    slhl_pkg::state_t                 state_next;
    logic [slhl_pkg::SAMPLE_BITS-1:0] value_next;
    logic                             locked_next;
    logic [slhl_pkg::SAMPLE_BITS-1:0] out_value_reg;
    logic                             is_locked_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid_next = in_accept || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign is_locked = is_locked_reg;

    slhl_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (sample),
        .state_next (state_next),
        .out_value  (value_next),
        .is_locked  (locked_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_len <= slhl_pkg::WINDOW_RESET;
            cfg_reg.tolerance  <= slhl_pkg::TOL_RESET;
            cfg_reg.bypass     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slhl_pkg::REG_WINDOW_LEN: cfg_reg.window_len <= cfg_data;
                slhl_pkg::REG_TOLERANCE:
                    cfg_reg.tolerance <= cfg_data[slhl_pkg::TOL_BITS-1:0];
                slhl_pkg::REG_BYPASS:     cfg_reg.bypass <= cfg_data[0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_value_reg <= value_next;
            is_locked_reg <= locked_next;
        end
    end

    // Bypass never reports a lock.
    a_bypass_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && cfg_reg.bypass |=> !is_locked)
        else $error("locked result produced in bypass");

    // Once locked, the lowest sample never rises above the held value.
    a_lowest_below_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.locked |-> state_reg.lowest <= state_reg.held)
        else $error("lowest sample above held value while locked");

    // State moves only on an accepted transaction.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg))
        else $error("state changed without an input transaction");

    // A delivered result with no new transaction empties the output register.
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !in_accept |=> !out_valid)
        else $error("result repeated after delivery");

endmodule
